// ----- sv/pim_pkg.sv -----
package pim_pkg;

   // Fixed field widths of the request and response transactions
   localparam int TID_W        = 4;
   localparam int PRIO_FIELD_W = 8;

   // Default wait queue depth
   localparam int MAX_THREADS_DEF = 16;

   // Priority bits that are kept; anything above the field width is dropped
   localparam int PRIO_BITS = 8;
   localparam int PRIO_W    = (PRIO_BITS < PRIO_FIELD_W) ? PRIO_BITS : PRIO_FIELD_W;

   typedef enum logic {
      OP_LOCK   = 1'b0,
      OP_UNLOCK = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STATUS_ACQUIRED         = 3'd0,
      STATUS_BLOCKED          = 3'd1,
      STATUS_RELEASED_IDLE    = 3'd2,
      STATUS_RELEASED_HANDOFF = 3'd3,
      STATUS_REJECTED_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      op_type                  op;
      logic [TID_W-1:0]        thread_id;
      logic [PRIO_FIELD_W-1:0] base_prio;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [TID_W-1:0]        handoff_thread;
      logic                    boost_valid;
      logic [TID_W-1:0]        boost_thread;
      logic [PRIO_FIELD_W-1:0] boost_prio;
      logic                    restore_valid;
      logic [TID_W-1:0]        restore_thread;
      logic                    owner_valid;
      logic [TID_W-1:0]        owner_thread;
   } rsp_type;

   // One waiter as stored in the wait queue
   typedef struct packed {
      logic [TID_W-1:0]  tid;
      logic [PRIO_W-1:0] prio;
   } waiter_type;

   // Wait queue control and status
   typedef struct packed {
      logic push;
      logic pop;
   } queue_cmd_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      waiter_type head;
   } queue_stat_type;

endpackage

// ----- sv/pim_wait_queue.sv -----
module pim_wait_queue #(
   parameter int MAX_THREADS = pim_pkg::MAX_THREADS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pim_pkg::queue_cmd_type cmd,
   input  pim_pkg::waiter_type    push_entry,
   output pim_pkg::queue_stat_type stat
);
   import pim_pkg::*;

   localparam int PTR_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CNT_W = $clog2(MAX_THREADS + 1);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   waiter_type mem [MAX_THREADS];
   waiter_type head_data_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(MAX_THREADS - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      head_in  = cmd.pop  ? next_ptr(head_ff) : head_ff;
      tail_in  = cmd.push ? next_ptr(tail_ff) : tail_ff;
      count_in = count_ff + CNT_W'(cmd.push) - CNT_W'(cmd.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Keep the entry at the next head prefetched; forward a push into an empty queue
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= push_entry;
      end
      if (cmd.push && (tail_ff == head_in)) begin
         head_data_ff <= push_entry;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(MAX_THREADS));
   assign stat.head  = head_data_ff;

endmodule

// ----- sv/priority_inheritance_mutex_top.sv -----
// Priority-inheritance mutex with a FIFO wait queue.
//
// Request channel (req_valid/req_ready/req_data): one lock or unlock
// transaction from a thread, carrying its id and base priority (lower
// number is more urgent). Response channel (rsp_valid/rsp_ready/rsp_data):
// exactly one response transaction per request, in request order, giving
// the status, any handoff to the oldest waiter, any priority boost of the
// owner, any restore of the old owner's priority and the owner afterward.
//
// An accepted request is loaded into the input register, then through the
// decision logic into the response register, and rsp_valid is high from
// then on. Throughput is one transaction per cycle while the receiver does
// not stall; the wait queue keeps its head entry prefetched in a register so
// a handoff needs no extra memory read.
//
// Reset (synchronous, active high) frees the mutex, empties the wait queue
// and drops both pipeline registers. When the receiver stalls, the response
// register holds its transaction and the input register holds the next
// one; req_ready falls only while both are full and rsp_ready is low.
module priority_inheritance_mutex_top #(
   parameter int MAX_THREADS = pim_pkg::MAX_THREADS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pim_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pim_pkg::rsp_type rsp_data
);
   import pim_pkg::*;

   // Input register
   logic    req_valid_ff, req_valid_in;
   req_type req_ff;

   // Response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Owner state (the owner is known exactly when the mutex is held)
   logic              held_ff, held_in;
   logic [TID_W-1:0]  owner_id_ff, owner_id_in;
   logic [PRIO_W-1:0] owner_prio_ff, owner_prio_in;

   logic              rsp_free;
   logic              advance;
   logic [PRIO_W-1:0] req_prio;

   queue_cmd_type  q_cmd;
   queue_stat_type q_stat;
   waiter_type     q_push_entry;

   // Advance the input register whenever the response register can take a result
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && rsp_free;
   assign req_ready = !req_valid_ff || rsp_free;

   assign req_prio = req_ff.base_prio[PRIO_W-1:0];

   assign q_push_entry.tid  = req_ff.thread_id;
   assign q_push_entry.prio = req_prio;

   pim_wait_queue #(
      .MAX_THREADS(MAX_THREADS)
   ) u_wait_queue (
      .clock      (clock),
      .reset      (reset),
      .cmd        (q_cmd),
      .push_entry (q_push_entry),
      .stat       (q_stat)
   );

   // Decide the transaction: owner update, queue command and response fields
   always_comb begin
      held_in       = held_ff;
      owner_id_in   = owner_id_ff;
      owner_prio_in = owner_prio_ff;
      q_cmd         = '0;
      rsp_in        = '0;

      if (advance) begin
         unique case (req_ff.op)
            OP_LOCK: begin
               if (!held_ff) begin
                  // Free mutex: grant at once
                  held_in       = 1'b1;
                  owner_id_in   = req_ff.thread_id;
                  owner_prio_in = req_prio;
                  rsp_in.status = STATUS_ACQUIRED;
               end else if (q_stat.full) begin
                  // No room to wait: drop the request untouched
                  rsp_in.status = STATUS_REJECTED_FULL;
               end else begin
                  // Queue the requester; lend its priority if it is more urgent
                  q_cmd.push = 1'b1;
                  rsp_in.status = STATUS_BLOCKED;
                  if (req_prio < owner_prio_ff) begin
                     rsp_in.boost_valid  = 1'b1;
                     rsp_in.boost_thread = owner_id_ff;
                     rsp_in.boost_prio   = PRIO_FIELD_W'(req_prio);
                  end
               end
            end
            OP_UNLOCK: begin
               // Clear the old owner's inheritance, whoever sends the unlock
               rsp_in.restore_valid  = held_ff;
               rsp_in.restore_thread = held_ff ? owner_id_ff : '0;
               if (!q_stat.empty) begin
                  // Hand ownership straight to the oldest waiter
                  q_cmd.pop             = 1'b1;
                  held_in               = 1'b1;
                  owner_id_in           = q_stat.head.tid;
                  owner_prio_in         = q_stat.head.prio;
                  rsp_in.handoff_thread = q_stat.head.tid;
                  rsp_in.status         = STATUS_RELEASED_HANDOFF;
               end else begin
                  held_in       = 1'b0;
                  owner_id_in   = '0;
                  owner_prio_in = '0;
                  rsp_in.status = STATUS_RELEASED_IDLE;
               end
            end
            default: begin
               rsp_in.status = STATUS_RELEASED_IDLE;
            end
         endcase
         rsp_in.owner_valid  = held_in;
         rsp_in.owner_thread = held_in ? owner_id_in : '0;
      end
   end

   always_comb begin
      req_valid_in = req_ready ? req_valid : req_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         held_ff       <= 1'b0;
         owner_id_ff   <= '0;
         owner_prio_ff <= '0;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         held_ff       <= held_in;
         owner_id_ff   <= owner_id_in;
         owner_prio_ff <= owner_prio_in;
      end
   end

   // Payload registers: load on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/pim_checker.sv -----
module pim_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pim_pkg::rsp_type rsp_data
);
   import pim_pkg::*;

   // A stalled response transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // An accepted request is followed by a response on offer
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("no response after an accepted request");

   // A handoff leaves the handed-off waiter as owner
   a_handoff_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_RELEASED_HANDOFF |->
         rsp_data.owner_valid && rsp_data.owner_thread == rsp_data.handoff_thread)
      else $error("handoff does not match new owner");

   // A boost only comes with a blocked lock and names the unchanged owner
   a_boost_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.boost_valid |->
         rsp_data.status == STATUS_BLOCKED && rsp_data.owner_valid &&
         rsp_data.owner_thread == rsp_data.boost_thread)
      else $error("boost outside a blocked lock");

   // An idle release leaves the mutex free with no owner reported
   a_idle_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_RELEASED_IDLE |->
         !rsp_data.owner_valid && rsp_data.owner_thread == '0 &&
         rsp_data.handoff_thread == '0 && !rsp_data.boost_valid)
      else $error("idle release reports an owner");

endmodule

bind priority_inheritance_mutex_top pim_checker u_pim_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- tb/mutex_outcome_checker.sv -----
module mutex_outcome_checker
   import pim_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      checked_count,
   output int      boost_count,
   output int      handoff_count,
   output int      full_count
);

   // Mirror of the mutex: owner registers and the waiter FIFO
   logic              held        = 1'b0;
   logic              owner_known = 1'b0;
   logic [TID_W-1:0]  owner_id    = '0;
   logic [PRIO_W-1:0] owner_prio  = '0;
   waiter_type        waiters[$];

   rsp_type owed[$];
   rsp_type want;
   int      errors   = 0;
   int      checked  = 0;
   int      boosts   = 0;
   int      handoffs = 0;
   int      fulls    = 0;

   // Apply one request to the mirror and return the response it must give
   function automatic rsp_type mutex_outcome(input req_type rq);
      rsp_type    r;
      waiter_type w;
      r = '0;
      if (rq.op == OP_LOCK) begin
         if (!held) begin
            held        = 1'b1;
            owner_known = 1'b1;
            owner_id    = rq.thread_id;
            owner_prio  = rq.base_prio[PRIO_W-1:0];
            r.status    = STATUS_ACQUIRED;
         end else if (waiters.size() >= MAX_THREADS_DEF) begin
            r.status = STATUS_REJECTED_FULL;
         end else begin
            if (owner_known && (rq.base_prio[PRIO_W-1:0] < owner_prio)) begin
               r.boost_valid  = 1'b1;
               r.boost_thread = owner_id;
               r.boost_prio   = PRIO_FIELD_W'(rq.base_prio[PRIO_W-1:0]);
            end
            w.tid  = rq.thread_id;
            w.prio = rq.base_prio[PRIO_W-1:0];
            waiters.push_back(w);
            r.status = STATUS_BLOCKED;
         end
      end else begin
         if (held && owner_known) begin
            r.restore_valid  = 1'b1;
            r.restore_thread = owner_id;
         end
         held        = 1'b0;
         owner_known = 1'b0;
         owner_id    = '0;
         owner_prio  = '0;
         r.status    = STATUS_RELEASED_IDLE;
         if (waiters.size() > 0) begin
            w                = waiters.pop_front();
            held             = 1'b1;
            owner_known      = 1'b1;
            owner_id         = w.tid;
            owner_prio       = w.prio;
            r.handoff_thread = w.tid;
            r.status         = STATUS_RELEASED_HANDOFF;
         end
      end
      r.owner_valid  = held;
      r.owner_thread = held ? owner_id : '0;
      return r;
   endfunction

   task automatic note_field(input string field, input int unsigned exp_val,
                             input int unsigned act_val);
      if (exp_val != act_val) begin
         if (errors < 10)
            $display("%0t: %s mismatch: expected %0d, got %0d",
                     $time, field, exp_val, act_val);
         errors++;
      end
   endtask

   task automatic compare_response(input rsp_type exp_rsp, input rsp_type act_rsp);
      note_field("status",         exp_rsp.status,         act_rsp.status);
      note_field("handoff_thread", exp_rsp.handoff_thread, act_rsp.handoff_thread);
      note_field("boost_valid",    exp_rsp.boost_valid,    act_rsp.boost_valid);
      note_field("boost_thread",   exp_rsp.boost_thread,   act_rsp.boost_thread);
      note_field("boost_prio",     exp_rsp.boost_prio,     act_rsp.boost_prio);
      note_field("restore_valid",  exp_rsp.restore_valid,  act_rsp.restore_valid);
      note_field("restore_thread", exp_rsp.restore_thread, act_rsp.restore_thread);
      note_field("owner_valid",    exp_rsp.owner_valid,    act_rsp.owner_valid);
      note_field("owner_thread",   exp_rsp.owner_thread,   act_rsp.owner_thread);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held        = 1'b0;
         owner_known = 1'b0;
         owner_id    = '0;
         owner_prio  = '0;
         waiters.delete();
         owed.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed.size() == 0) begin
               if (errors < 10)
                  $display("%0t: response with none outstanding: status %0d owner %0d",
                           $time, rsp_data.status, rsp_data.owner_thread);
               errors++;
            end else begin
               want = owed.pop_front();
               compare_response(want, rsp_data);
               checked++;
               if (want.boost_valid) boosts++;
               if (want.status == STATUS_RELEASED_HANDOFF) handoffs++;
               if (want.status == STATUS_REJECTED_FULL) fulls++;
            end
         end
         if (req_valid && req_ready)
            owed.push_back(mutex_outcome(req_data));
      end
      // Publish with nonblocking updates so the stimulus side reads settled values
      pending_count <= owed.size();
      fail_count    <= errors;
      checked_count <= checked;
      boost_count   <= boosts;
      handoff_count <= handoffs;
      full_count    <= fulls;
   end

endmodule

// ----- tb/priority_inheritance_mutex_top_tb.sv -----
module priority_inheritance_mutex_top_tb;
   import pim_pkg::*;

   localparam int CLK_PERIOD  = 20;
   localparam int PHASE_ITEMS = 200;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int checked_count;
   int boost_count;
   int handoff_count;
   int full_count;

   // Percentages of cycles in which the sender idles / the receiver stalls
   int idle_pct  = 0;
   int stall_pct = 0;

   always #(CLK_PERIOD/2) clock = ~clock;

   priority_inheritance_mutex_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Watch both channels, predict every response and compare it
   mutex_outcome_checker lock_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .boost_count   (boost_count),
      .handoff_count (handoff_count),
      .full_count    (full_count)
   );

   // Receiver: decide afresh every cycle whether to take a response
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Hard stop in case the block hangs
   initial begin
      #(CLK_PERIOD * 200000);
      $display("Verification failed");
      $finish;
   end

   function automatic req_type make_req(input op_type op, input logic [TID_W-1:0] tid,
                                        input logic [PRIO_FIELD_W-1:0] prio);
      req_type rq;
      rq.op        = op;
      rq.thread_id = tid;
      rq.base_prio = prio;
      return rq;
   endfunction

   // Random request; lock_pct steers whether the wait queue fills or drains
   function automatic req_type random_request(input int lock_pct);
      req_type rq;
      rq.op        = ($urandom_range(99) < lock_pct) ? OP_LOCK : OP_UNLOCK;
      rq.thread_id = TID_W'($urandom_range(15));
      case ($urandom_range(7))
         0:       rq.base_prio = '0;
         1:       rq.base_prio = '1;
         default: rq.base_prio = PRIO_FIELD_W'($urandom_range(255));
      endcase
      return rq;
   endfunction

   // Offer one transaction, idling first at random, and hold it until taken.
   // Returns at the edge where it is accepted.
   task automatic push_request(input req_type rq);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and hold off until every outstanding response has come back.
   // The first edge lets the checker register the last accepted request.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int lock_pct;
      int burst;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, no idling on either side.
      // Unlock while free: released idle, no restore.
      push_request(make_req(OP_UNLOCK, 4'd9, 8'd77));
      // Free lock grants at once.
      push_request(make_req(OP_LOCK, 4'd3, 8'd200));
      // Owner locks again: queued behind itself, equal priority gives no boost.
      push_request(make_req(OP_LOCK, 4'd3, 8'd200));
      // Most urgent priority boosts the owner.
      push_request(make_req(OP_LOCK, 4'd0, 8'd0));
      // Least urgent: no boost.
      push_request(make_req(OP_LOCK, 4'd15, 8'd255));
      // Repeated boost is compared against the base priority, not the inherited one.
      push_request(make_req(OP_LOCK, 4'd5, 8'd199));
      // Fill the queue to its full depth of sixteen waiters.
      for (int i = 0; i < 12; i++)
         push_request(make_req(OP_LOCK, TID_W'(i), PRIO_FIELD_W'($urandom_range(255))));
      // Lock on a full queue is rejected without a boost.
      push_request(make_req(OP_LOCK, 4'd10, 8'd1));
      // Unlock by a thread that does not own the mutex still hands off.
      push_request(make_req(OP_UNLOCK, 4'd12, 8'd0));
      // Unlock with all priority bits set: priority is ignored on unlock.
      push_request(make_req(OP_UNLOCK, 4'd3, 8'd255));

      // Random part in four handshake phases; drain fully between phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 61; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 61; end
            default: begin idle_pct = 31; stall_pct <= 31; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // Bursts lean toward filling or emptying the wait queue
            case ($urandom_range(3))
               0:       lock_pct = 20;
               1:       lock_pct = 50;
               2:       lock_pct = 65;
               default: lock_pct = 90;
            endcase
            burst = $urandom_range(8, 40);
            for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
               push_request(random_request(lock_pct));
               sent++;
            end
         end
         drain_responses();
      end

      // Let any stray response surface before the verdict
      stall_pct <= 0;
      repeat (10) @(posedge clock);

      $display("Covered %0d lock/unlock transactions under four idle/stall mixes:",
               checked_count);
      $display("  %0d owner boosts, %0d handoffs to waiters, %0d full-queue rejections",
               boost_count, handoff_count, full_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
